// File: rtl/phtl_pkg.sv
// ----------------------------------------------------------------------------
// phtl_pkg
// Shared types and the permutation table for the three-lane Pearson hash.
// ----------------------------------------------------------------------------
package phtl_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HASH_W = 24;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [1:0]        lane_ofs_t;

    localparam lane_ofs_t LANE_OFS_ZERO = 2'd0;
    localparam lane_ofs_t LANE_OFS_ONE  = 2'd1;
    localparam lane_ofs_t LANE_OFS_TWO  = 2'd2;

    typedef struct packed {
        logic step;
        logic clear;
    } lane_ctrl_t;

    localparam byte_t PERM_ROM [256] = '{
        8'd1,   8'd87,  8'd49,  8'd12,  8'd176, 8'd178, 8'd102, 8'd166,
        8'd121, 8'd193, 8'd6,   8'd84,  8'd249, 8'd230, 8'd44,  8'd163,
        8'd14,  8'd197, 8'd213, 8'd181, 8'd161, 8'd85,  8'd218, 8'd80,
        8'd64,  8'd239, 8'd24,  8'd226, 8'd236, 8'd142, 8'd38,  8'd200,
        8'd110, 8'd177, 8'd104, 8'd103, 8'd141, 8'd253, 8'd255, 8'd50,
        8'd77,  8'd101, 8'd81,  8'd18,  8'd45,  8'd96,  8'd31,  8'd222,
        8'd25,  8'd107, 8'd190, 8'd70,  8'd86,  8'd237, 8'd240, 8'd34,
        8'd72,  8'd242, 8'd20,  8'd214, 8'd244, 8'd227, 8'd149, 8'd235,
        8'd97,  8'd234, 8'd57,  8'd22,  8'd60,  8'd250, 8'd82,  8'd175,
        8'd208, 8'd5,   8'd127, 8'd199, 8'd111, 8'd62,  8'd135, 8'd248,
        8'd174, 8'd169, 8'd211, 8'd58,  8'd66,  8'd154, 8'd106, 8'd195,
        8'd245, 8'd171, 8'd17,  8'd187, 8'd182, 8'd179, 8'd0,   8'd243,
        8'd132, 8'd56,  8'd148, 8'd75,  8'd128, 8'd133, 8'd158, 8'd100,
        8'd130, 8'd126, 8'd91,  8'd13,  8'd153, 8'd246, 8'd216, 8'd219,
        8'd119, 8'd68,  8'd223, 8'd78,  8'd83,  8'd88,  8'd201, 8'd99,
        8'd122, 8'd11,  8'd92,  8'd32,  8'd136, 8'd114, 8'd52,  8'd10,
        8'd138, 8'd30,  8'd48,  8'd183, 8'd156, 8'd35,  8'd61,  8'd26,
        8'd143, 8'd74,  8'd251, 8'd94,  8'd129, 8'd162, 8'd63,  8'd152,
        8'd170, 8'd7,   8'd115, 8'd167, 8'd241, 8'd206, 8'd3,   8'd150,
        8'd55,  8'd59,  8'd151, 8'd220, 8'd90,  8'd53,  8'd23,  8'd131,
        8'd125, 8'd173, 8'd15,  8'd238, 8'd79,  8'd95,  8'd89,  8'd16,
        8'd105, 8'd137, 8'd225, 8'd224, 8'd217, 8'd160, 8'd37,  8'd123,
        8'd118, 8'd73,  8'd2,   8'd157, 8'd46,  8'd116, 8'd9,   8'd145,
        8'd134, 8'd228, 8'd207, 8'd212, 8'd202, 8'd215, 8'd69,  8'd229,
        8'd27,  8'd188, 8'd67,  8'd124, 8'd168, 8'd252, 8'd42,  8'd4,
        8'd29,  8'd108, 8'd21,  8'd247, 8'd19,  8'd205, 8'd39,  8'd203,
        8'd233, 8'd40,  8'd186, 8'd147, 8'd198, 8'd192, 8'd155, 8'd33,
        8'd164, 8'd191, 8'd98,  8'd204, 8'd165, 8'd180, 8'd117, 8'd76,
        8'd140, 8'd36,  8'd210, 8'd172, 8'd41,  8'd54,  8'd159, 8'd8,
        8'd185, 8'd232, 8'd113, 8'd196, 8'd231, 8'd47,  8'd146, 8'd120,
        8'd51,  8'd65,  8'd28,  8'd144, 8'd254, 8'd221, 8'd93,  8'd189,
        8'd194, 8'd139, 8'd112, 8'd43,  8'd71,  8'd109, 8'd184, 8'd209
    };

endpackage

// File: rtl/pearson_hash_three_lane_top.sv
// ----------------------------------------------------------------------------
// pearson_hash_three_lane_top
// Three-lane Pearson string hash producing a 24-bit value per terminated string.
// ----------------------------------------------------------------------------
// Accepts one string byte per cycle unless a held terminator stalls the
// input. Each nonzero word steps three 8-bit lanes through the permutation
// table; a zero word ends the string, sends lane0/lane1/lane2 out as one
// 24-bit hash word and clears the lanes. A byte is held in an input register
// and retired there by the lane table lookups, so the sustained rate is one
// byte per cycle while no terminator is held; the hash word is loaded into the
// output register at the edge that retires the terminator from the input
// register. A terminator waits in the input register only while a previous
// hash word is still not taken.
module pearson_hash_three_lane_top
    import phtl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [HASH_W-1:0] m_hash_value
);

    logic              in_valid_reg;
    byte_t             in_byte_reg;
    logic              out_valid_reg;
    logic [HASH_W-1:0] out_hash_reg;
    logic              out_valid_next;
    logic              is_term;
    logic              advance;
    lane_ctrl_t        lane_ctrl;
    byte_t             acc0;
    byte_t             acc1;
    byte_t             acc2;

    assign is_term = (in_byte_reg == '0);
    assign advance = in_valid_reg && (!is_term || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign lane_ctrl.step  = advance && !is_term;
    assign lane_ctrl.clear = advance && is_term;

    phtl_lane u_lane0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lane_ctrl),
        .data_byte (in_byte_reg),
        .lane_ofs  (LANE_OFS_ZERO),
        .acc       (acc0)
    );

    phtl_lane u_lane1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lane_ctrl),
        .data_byte (in_byte_reg),
        .lane_ofs  (LANE_OFS_ONE),
        .acc       (acc1)
    );

    phtl_lane u_lane2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lane_ctrl),
        .data_byte (in_byte_reg),
        .lane_ofs  (LANE_OFS_TWO),
        .acc       (acc2)
    );

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // result word register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (lane_ctrl.clear) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_ctrl.clear) begin
            out_hash_reg <= {acc0, acc1, acc2};
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;

endmodule

// File: rtl/phtl_lane.sv
// ----------------------------------------------------------------------------
// phtl_lane
// One Pearson accumulator lane: table lookup on acc xor (byte + lane offset).
// ----------------------------------------------------------------------------
module phtl_lane
    import phtl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_ctrl_t ctrl,
    input  byte_t      data_byte,
    input  lane_ofs_t  lane_ofs,
    output byte_t      acc
);

    byte_t acc_reg;
    byte_t acc_next;
    byte_t byte_ofs;
    byte_t rom_idx;

    assign byte_ofs = data_byte + {6'd0, lane_ofs};
    assign rom_idx  = acc_reg ^ byte_ofs;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.step) begin
            acc_next = PERM_ROM[rom_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
